// ===== design/fsa_pkg.sv =====
// Shared constants and status type for the fraction sum accumulator.
`timescale 1ns / 1ps

package fsa_pkg;

	localparam int NUM_W           = 32;  // term and sum numerator width
	localparam int DEN_W           = 31;  // term and sum denominator width
	localparam int MUL_W           = 32;  // shared multiplier operand width
	localparam int WIDE_W          = 2 * MUL_W;  // cross products, gcd, divider
	localparam int SHIFT_W         = $clog2(WIDE_W);
	localparam int CNT_W           = $clog2(WIDE_W + 1);
	localparam int VALUE_WIDTH_DEF = 32;

	// status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;   // one-cycle pulse, result valid in the same cycle
	} fsa_unit_sts_t;

endpackage

// ===== design/fsa_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
`timescale 1ns / 1ps

module fsa_mul
	import fsa_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  op_a,
	input  logic signed [MUL_W-1:0]  op_b,
	output logic signed [WIDE_W-1:0] product_s1
);

	logic signed [WIDE_W-1:0] product;

	assign product = op_a * op_b;

	always_ff @(posedge clk) begin
		product_s1 <= product;
	end

endmodule

// ===== design/fsa_gcd.sv =====
// Iterative binary gcd unit: one compare/subtract/shift step per cycle.
`timescale 1ns / 1ps

module fsa_gcd
	import fsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] x,
	input  logic [WIDE_W-1:0] y,
	output logic [WIDE_W-1:0] g,
	output fsa_unit_sts_t     sts
);

	logic [WIDE_W-1:0]  u_q;
	logic [WIDE_W-1:0]  v_q;
	logic [SHIFT_W-1:0] k_q;
	logic [WIDE_W-1:0]  g_q;
	logic               busy_q;
	logic               done_q;
	logic [WIDE_W-1:0]  u_minus_v;
	logic [WIDE_W-1:0]  v_minus_u;
	logic               u_ge_v;

	assign u_ge_v    = (u_q >= v_q);
	assign u_minus_v = u_q - v_q;
	assign v_minus_u = v_q - u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			u_q    <= '0;
			v_q    <= '0;
			k_q    <= '0;
			g_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				u_q    <= x;
				v_q    <= y;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (u_q == '0 || v_q == '0) begin
					// one side is zero, so the OR is the other side
					g_q    <= (u_q | v_q) << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					case ({u_q[0], v_q[0]})
						2'b00: begin
							u_q <= u_q >> 1;
							v_q <= v_q >> 1;
							k_q <= k_q + 1'b1;
						end
						2'b01: begin
							u_q <= u_q >> 1;
						end
						2'b10: begin
							v_q <= v_q >> 1;
						end
						default: begin
							// both odd: difference is even, halve it at once
							if (u_ge_v) begin
								u_q <= u_minus_v >> 1;
							end else begin
								v_q <= v_minus_u >> 1;
							end
						end
					endcase
				end
			end
		end
	end

	assign g        = g_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ===== design/fsa_div.sv =====
// Restoring divider, one quotient bit per cycle; used for exact division by the gcd.
`timescale 1ns / 1ps

module fsa_div
	import fsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WIDE_W-1:0] dividend,
	input  logic [WIDE_W-1:0] divisor,
	output logic [WIDE_W-1:0] quotient,
	output fsa_unit_sts_t     sts
);

	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] quo_q;
	logic [WIDE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WIDE_W:0]   shifted;
	logic [WIDE_W:0]   trial;
	logic              fits;

	assign shifted = {rem_q, quo_q[WIDE_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= CNT_W'(WIDE_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= trial[WIDE_W-1:0];
					quo_q <= {quo_q[WIDE_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[WIDE_W-1:0];
					quo_q <= {quo_q[WIDE_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

// ===== design/fraction_sum_accumulator.sv =====
// Top level: running rational sum of a fraction stream, reduced by gcd after every term.
`timescale 1ns / 1ps
//
// Slave channel s_*: one fraction per transfer. tdata holds the signed numerator in
// [31:0] and the denominator in [62:32]; tlast closes a sequence. Master channel m_*:
// one transfer per closed sequence with the reduced sum and, in tuser, a sticky
// overflow flag that is set when a term was dropped (zero denominator, or a reduced
// part that no longer fits VALUE_WIDTH bits).
// Each term runs through a small sequencer: three products on the shared 32x32
// multiplier (a*d, c*b, b*d), a binary gcd on a 64-bit subtract/shift unit, then
// two exact divisions by the gcd on a restoring divider. The time from transfer to
// the next s_tready is set mostly by the gcd loop and the one-bit-per-cycle divider;
// a term with a zero denominator skips the arithmetic and goes straight to emit.
// s_tready is high only while idle.
// The result sits in an output register: a stalled receiver does not block the next
// sequence until its last term finishes, then the block waits for m_tready.
// Reset (arst_n low, asynchronous) returns the sum to 0/1, clears the flag and
// drops any held result. After every emitted result the sum returns to 0/1.

module fraction_sum_accumulator
	import fsa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] term_numerator, [62:32] term_denominator
	input  logic        s_tlast,   // last_term
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] sum_numerator, [62:32] sum_denominator
	output logic        m_tuser    // overflow
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_AD,
		ST_MUL_CB,
		ST_MUL_BD,
		ST_SUM,
		ST_GCD_GO,
		ST_GCD_WAIT,
		ST_DIV_MAG_GO,
		ST_DIV_MAG,
		ST_DIV_DEN_GO,
		ST_DIV_DEN,
		ST_CHECK,
		ST_EMIT
	} state_t;

	localparam logic [WIDE_W-1:0] LIMIT = WIDE_W'(1) << (VALUE_WIDTH - 1);

	state_t                          state_q;
	logic signed [VALUE_WIDTH-1:0]   acc_num_q;
	logic        [VALUE_WIDTH-2:0]   acc_den_q;
	logic                            ovf_q;
	logic signed [NUM_W-1:0]         c_q;
	logic        [DEN_W-1:0]         d_q;
	logic                            last_q;
	logic signed [WIDE_W-1:0]        sum_q;
	logic                            neg_q;
	logic        [WIDE_W-1:0]        mag_q;
	logic        [WIDE_W-1:0]        den_q;
	logic        [WIDE_W-1:0]        g_q;
	logic                            m_tvalid_q;
	logic        [NUM_W-1:0]         out_num_q;
	logic        [DEN_W-1:0]         out_den_q;
	logic                            out_ovf_q;

	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [WIDE_W-1:0] product_s1;
	logic [WIDE_W-1:0]        gcd_g;
	fsa_unit_sts_t            gcd_sts;
	fsa_unit_sts_t            div_sts;
	logic [WIDE_W-1:0]        div_dividend;
	logic [WIDE_W-1:0]        div_quotient;
	logic                     s_fire;
	logic                     out_free;
	logic                     emit_fire;
	logic                     too_wide;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	// a new sum enters the output register this cycle
	assign emit_fire = (state_q == ST_EMIT) && last_q && out_free;

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_MUL_AD: begin
				op_a = MUL_W'(acc_num_q);
				op_b = MUL_W'(d_q);
			end
			ST_MUL_CB: begin
				op_a = c_q;
				op_b = MUL_W'(acc_den_q);
			end
			ST_MUL_BD: begin
				op_a = MUL_W'(acc_den_q);
				op_b = MUL_W'(d_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	fsa_mul u_mul (
		.clk        (clk),
		.op_a       (op_a),
		.op_b       (op_b),
		.product_s1 (product_s1)
	);

	fsa_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_GCD_GO),
		.x      (mag_q),
		.y      (den_q),
		.g      (gcd_g),
		.sts    (gcd_sts)
	);

	assign div_dividend = (state_q == ST_DIV_DEN_GO) ? den_q : mag_q;

	fsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_DIV_MAG_GO) || (state_q == ST_DIV_DEN_GO)),
		.dividend (div_dividend),
		.divisor  (g_q),
		.quotient (div_quotient),
		.sts      (div_sts)
	);

	// reduced parts must fit VALUE_WIDTH; a negative numerator may reach -LIMIT
	assign too_wide = (den_q >= LIMIT) || (neg_q ? (mag_q > LIMIT) : (mag_q >= LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			acc_num_q  <= '0;
			acc_den_q  <= (VALUE_WIDTH-1)'(1);
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			c_q        <= '0;
			d_q        <= '0;
			last_q     <= 1'b0;
			sum_q      <= '0;
			neg_q      <= 1'b0;
			mag_q      <= '0;
			den_q      <= '0;
			g_q        <= '0;
			out_num_q  <= '0;
			out_den_q  <= '0;
			out_ovf_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !emit_fire) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						c_q    <= s_tdata[NUM_W-1:0];
						d_q    <= s_tdata[NUM_W +: DEN_W];
						last_q <= s_tlast;
						if (s_tdata[NUM_W +: DEN_W] == '0) begin
							// zero denominator: drop the term
							ovf_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_MUL_AD;
						end
					end
				end
				ST_MUL_AD: state_q <= ST_MUL_CB;
				ST_MUL_CB: begin
					sum_q   <= product_s1;              // a*d
					state_q <= ST_MUL_BD;
				end
				ST_MUL_BD: begin
					sum_q   <= sum_q + product_s1;      // + c*b
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					den_q   <= $unsigned(product_s1);   // b*d, always positive
					neg_q   <= sum_q[WIDE_W-1];
					mag_q   <= sum_q[WIDE_W-1] ? (WIDE_W'(0) - $unsigned(sum_q))
					                           : $unsigned(sum_q);
					state_q <= ST_GCD_GO;
				end
				ST_GCD_GO: state_q <= ST_GCD_WAIT;
				ST_GCD_WAIT: begin
					if (gcd_sts.done) begin
						g_q     <= gcd_g;
						state_q <= ST_DIV_MAG_GO;
					end
				end
				ST_DIV_MAG_GO: state_q <= ST_DIV_MAG;
				ST_DIV_MAG: begin
					if (div_sts.done) begin
						mag_q   <= div_quotient;
						state_q <= ST_DIV_DEN_GO;
					end
				end
				ST_DIV_DEN_GO: state_q <= ST_DIV_DEN;
				ST_DIV_DEN: begin
					if (div_sts.done) begin
						den_q   <= div_quotient;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (too_wide) begin
						ovf_q <= 1'b1;
					end else begin
						acc_num_q <= neg_q ? VALUE_WIDTH'(WIDE_W'(0) - mag_q)
						                   : VALUE_WIDTH'(mag_q);
						acc_den_q <= den_q[VALUE_WIDTH-2:0];
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_num_q  <= NUM_W'(acc_num_q);
						out_den_q  <= DEN_W'(acc_den_q);
						out_ovf_q  <= ovf_q;
						acc_num_q  <= '0;
						acc_den_q  <= (VALUE_WIDTH-1)'(1);
						ovf_q      <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_den_q, out_num_q};
	assign m_tuser  = out_ovf_q;

`ifndef NO_ASSERTIONS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		acc_den_q != '0)
		else $error("accumulated denominator is zero");

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!gcd_sts.busy && !div_sts.busy))
		else $error("input accepted while an iterative unit is busy");

	a_gcd_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_sts.done |-> (state_q == ST_GCD_WAIT))
		else $error("gcd finished outside its wait state");

	a_div_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV_MAG || state_q == ST_DIV_DEN))
		else $error("divider finished outside a wait state");

	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_MAG_GO) |-> (g_q != '0))
		else $error("division by a zero gcd");
`endif

endmodule
